FILE: rtl/core/page_frame_run_allocator_macros.svh
// Assertion macros for the page frame run allocator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PAGE_FRAME_RUN_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_RUN_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PFRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pfra_pkg.sv
// Types and constants shared by the page frame run allocator.
// No dependencies.
package pfra_pkg;

  localparam int FUNC_W = 2;
  localparam int RUNP_W = 6;
  localparam int PIDX_W = 10;
  localparam int CNT_W  = 11;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT,
    FN_KALLOC,
    FN_UALLOC,
    FN_FREE
  } func_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_RUN,
    ST_NOT_START,
    ST_BAD_COUNT
  } status_t;

  typedef enum logic [1:0] {
    FS_FREE  = 2'd0,
    FS_FIXED = 2'd1,
    FS_USER  = 2'd2
  } frame_t;

  typedef enum logic [0:0] {
    CFG_TOTAL,
    CFG_RESERVED
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_CLAIM_RD,
    S_CLAIM_WR,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    func_t             func;
    logic [RUNP_W-1:0] run_pages;
    logic [PIDX_W-1:0] free_index;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [PIDX_W-1:0] page_index;
    logic              evict;
    logic [CNT_W-1:0]  used_pages;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] total_pages;
    logic [CNT_W-1:0] reserved_pages;
  } cfg_regs_t;

  localparam logic [CNT_W-1:0] TOTAL_RST    = 11'd1024;
  localparam logic [CNT_W-1:0] RESERVED_RST = 11'd0;

endpackage

FILE: rtl/core/pfra_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/pfra_seq.sv
// Sequencer and datapath of the page frame run allocator: scan, claim, free,
// init and clearing sweeps over the frame RAM, plus the result register. Uses pfra_pkg.
module pfra_seq #(
  parameter int NUM_PAGES = 1024,
  parameter int MAX_RUN   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pfra_pkg::cfg_regs_t                   cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pfra_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pfra_pkg::out_item_t                   out_data,
  output logic                                  ram_we,
  output logic [$clog2(NUM_PAGES)-1:0]          ram_waddr,
  output logic [$clog2(MAX_RUN + 1)+1:0]        ram_wdata,
  output logic                                  ram_re,
  output logic [$clog2(NUM_PAGES)-1:0]          ram_raddr,
  input  logic [$clog2(MAX_RUN + 1)+1:0]        ram_rdata
);
  import pfra_pkg::*;

  localparam int AW  = $clog2(NUM_PAGES);
  localparam int CW  = $clog2(NUM_PAGES + 1);
  localparam int TW  = (CW > CNT_W) ? CW : CNT_W;
  localparam int RLW = $clog2(MAX_RUN + 1);
  localparam int DW  = 2 + RLW;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    lim_r, lim_nxt;
  logic [CW-1:0]    piu_r, piu_nxt;
  logic             dv_r, dv_nxt;
  logic [CW-1:0]    issue_r, issue_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [RLW-1:0]   run_r, run_nxt;
  logic [RLW-1:0]   user_r, user_nxt;
  logic [RLW-1:0]   n_r, n_nxt;
  logic [RLW-1:0]   cnt_r, cnt_nxt;
  logic [RLW-1:0]   len_r, len_nxt;
  frame_t           kind_r, kind_nxt;
  logic             allow_r, allow_nxt;
  status_t          status_r, status_nxt;
  logic [PIDX_W-1:0] page_r, page_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [CW-1:0]    t_eff, r_eff;
  logic             in_fire, slot_free, bad_cnt, fi_oob;
  logic [1:0]       rd_fs;
  logic [RLW-1:0]   rd_len;
  logic             rd_user, eligible, scan_issue, scan_hit, scan_miss;
  logic [RLW-1:0]   run_inc, user_tot, cnt_inc, free_len;
  logic             claim_go, claim_last, free_bad, free_more, sweep_end;
  logic [CW-1:0]    ptr_inc_c, piu_hit;
  logic [AW-1:0]    start_c;
  logic             out_load;
  out_item_t        out_d;

  assign t_eff = (TW'(cfg.total_pages) > TW'(NUM_PAGES)) ? CW'(NUM_PAGES)
                                                         : CW'(cfg.total_pages);
  assign r_eff = (TW'(cfg.reserved_pages) > TW'(t_eff)) ? t_eff
                                                         : CW'(cfg.reserved_pages);

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign bad_cnt   = (in_data.run_pages == '0) || (in_data.run_pages > RUNP_W'(MAX_RUN));
  assign fi_oob    = TW'(in_data.free_index) >= TW'(t_eff);

  assign rd_fs      = ram_rdata[DW-1:RLW];
  assign rd_len     = ram_rdata[RLW-1:0];
  assign rd_user    = (rd_fs == FS_USER);
  assign eligible   = (rd_fs == FS_FREE) || (allow_r && rd_user);
  assign scan_issue = issue_r < t_eff;
  assign run_inc    = run_r + RLW'(1);
  assign scan_hit   = dv_r && eligible && (run_inc == n_r);
  assign scan_miss  = !dv_r && !scan_issue;
  assign user_tot   = user_r + RLW'(rd_user);
  assign start_c    = AW'(CW'(idx_r) + CW'(1) - CW'(n_r));
  assign piu_hit    = piu_r + CW'(n_r) - CW'(user_tot);

  assign cnt_inc    = cnt_r + RLW'(1);
  assign claim_go   = !rd_user || slot_free;
  assign claim_last = (cnt_inc == n_r);
  assign free_len   = (cnt_r == '0) ? rd_len : len_r;
  assign free_bad   = (cnt_r == '0) && (rd_len == '0);
  assign ptr_inc_c  = CW'(ptr_r) + CW'(1);
  assign free_more  = (cnt_inc < free_len) && (ptr_inc_c < t_eff);
  assign sweep_end  = (ptr_r == AW'(NUM_PAGES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sweep_end) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            FN_INIT:   state_nxt = S_INIT;
            FN_KALLOC: state_nxt = bad_cnt ? S_DONE : S_SCAN;
            FN_UALLOC: state_nxt = S_SCAN;
            FN_FREE:   state_nxt = fi_oob ? S_DONE : S_FREE_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        if (sweep_end) state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_CLAIM_RD;
        end else if (scan_miss) begin
          state_nxt = S_DONE;
        end
      end
      S_CLAIM_RD: state_nxt = S_CLAIM_WR;
      S_CLAIM_WR: begin
        if (claim_go) state_nxt = claim_last ? S_DONE : S_CLAIM_RD;
      end
      S_FREE_RD: state_nxt = S_FREE_WR;
      S_FREE_WR: begin
        if (free_bad || !free_more) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FREE_RD;
        end
      end
      S_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM and result outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ptr_r;
    out_load  = 1'b0;
    out_d     = '{status: ST_OK, page_index: PIDX_W'(ptr_r), evict: 1'b1,
                  used_pages: CNT_W'(piu_r), last: 1'b0};
    case (state_r)
      S_CLEAR, S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {(CW'(ptr_r) < lim_r) ? FS_FIXED : FS_FREE, {RLW{1'b0}}};
      end
      S_SCAN: begin
        ram_re    = scan_issue;
        ram_raddr = issue_r[AW-1:0];
      end
      S_CLAIM_RD, S_FREE_RD: begin
        ram_re = 1'b1;
      end
      S_CLAIM_WR: begin
        ram_we    = claim_go;
        ram_wdata = {kind_r, (cnt_r == '0) ? n_r : {RLW{1'b0}}};
        out_load  = rd_user && slot_free;
      end
      S_FREE_WR: begin
        ram_we    = !free_bad;
        ram_wdata = {FS_FREE, {RLW{1'b0}}};
      end
      S_DONE: begin
        out_load = slot_free;
        out_d    = '{status: status_r, page_index: page_r, evict: 1'b0,
                     used_pages: CNT_W'(piu_r), last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    ptr_nxt    = ptr_r;
    lim_nxt    = lim_r;
    piu_nxt    = piu_r;
    dv_nxt     = 1'b0;
    issue_nxt  = issue_r;
    idx_nxt    = issue_r[AW-1:0];
    run_nxt    = run_r;
    user_nxt   = user_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    kind_nxt   = kind_r;
    allow_nxt  = allow_r;
    status_nxt = status_r;
    page_nxt   = page_r;
    case (state_r)
      S_CLEAR, S_INIT: begin
        ptr_nxt = sweep_end ? '0 : ptr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          ptr_nxt    = '0;
          cnt_nxt    = '0;
          issue_nxt  = '0;
          run_nxt    = '0;
          user_nxt   = '0;
          allow_nxt  = (piu_r >= t_eff);
          page_nxt   = '0;
          status_nxt = ST_NO_RUN;
          case (in_data.func)
            FN_INIT: begin
              lim_nxt    = r_eff;
              piu_nxt    = r_eff;
              status_nxt = ST_OK;
            end
            FN_KALLOC: begin
              n_nxt    = RLW'(in_data.run_pages);
              kind_nxt = FS_FIXED;
              if (bad_cnt) status_nxt = ST_BAD_COUNT;
            end
            FN_UALLOC: begin
              n_nxt    = RLW'(1);
              kind_nxt = FS_USER;
            end
            FN_FREE: begin
              ptr_nxt    = AW'(in_data.free_index);
              page_nxt   = in_data.free_index;
              status_nxt = fi_oob ? ST_NOT_START : ST_OK;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        dv_nxt = scan_issue;
        if (scan_issue) issue_nxt = issue_r + CW'(1);
        if (dv_r) begin
          if (eligible) begin
            run_nxt  = run_inc;
            user_nxt = user_tot;
          end else begin
            run_nxt  = '0;
            user_nxt = '0;
          end
        end
        if (scan_hit) begin
          ptr_nxt    = start_c;
          cnt_nxt    = '0;
          piu_nxt    = piu_hit;
          status_nxt = ST_OK;
          page_nxt   = PIDX_W'(start_c);
        end
      end
      S_CLAIM_WR: begin
        if (claim_go) begin
          cnt_nxt = cnt_inc;
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_FREE_WR: begin
        if (free_bad) begin
          status_nxt = ST_NOT_START;
        end else begin
          len_nxt = free_len;
          cnt_nxt = cnt_inc;
          ptr_nxt = ptr_r + AW'(1);
          if ((rd_fs != FS_FREE) && (piu_r != '0)) piu_nxt = piu_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_data_nxt  = out_load ? out_d : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      lim_r       <= '0;
      piu_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      lim_r       <= lim_nxt;
      piu_r       <= piu_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_r    <= issue_nxt;
    idx_r      <= idx_nxt;
    run_r      <= run_nxt;
    user_r     <= user_nxt;
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    len_r      <= len_nxt;
    kind_r     <= kind_nxt;
    allow_r    <= allow_nxt;
    status_r   <= status_nxt;
    page_r     <= page_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/page_frame_run_allocator.sv
// Page frame run allocator: config registers, frame RAM and sequencer.
// Depends on pfra_pkg, pfra_ram, pfra_seq and page_frame_run_allocator_macros.svh.
//
// Usage: commands arrive on in_* (valid/ready), one beat per command; each
// command produces one or more result beats on out_*, the final one with
// last set. Kernel and user allocations first emit one beat per user frame
// being evicted, then the final beat with the start index. Registers
// total_pages and reserved_pages are written on cfg_* (always ready); the user
// must write them only while idle; the block does not enforce this. One command
// is in work at a time; the frame RAM (state and run length per frame, one read
// and one write port) sets the steps of each command:
//   init        one RAM write per frame
//   allocation  a scan (one frame read per cycle), then a read and a write per
//               page of the run, then the final beat
//   free        a read and a write per page released, then the final beat
// Reset runs a clearing pass over the RAM with in_ready low. The final beat
// sits in an output register: the next command is taken while it waits; a
// stalled receiver holds back eviction beats and the sequencer waits on them.
module page_frame_run_allocator #(
  parameter int NUM_PAGES = 1024,
  parameter int MAX_RUN   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pfra_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pfra_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  pfra_pkg::cfg_idx_t             cfg_index,
  input  logic [pfra_pkg::CNT_W-1:0]     cfg_data
);
  import pfra_pkg::*;

`include "page_frame_run_allocator_macros.svh"

  localparam int AW = $clog2(NUM_PAGES);
  localparam int DW = 2 + $clog2(MAX_RUN + 1);

  cfg_regs_t     cfg_r, cfg_nxt;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOTAL:    cfg_nxt.total_pages    = cfg_data;
        CFG_RESERVED: cfg_nxt.reserved_pages = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{total_pages: TOTAL_RST, reserved_pages: RESERVED_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pfra_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_PAGES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfra_seq #(
    .NUM_PAGES (NUM_PAGES),
    .MAX_RUN   (MAX_RUN)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // a taken command keeps the block busy for at least the next cycle
  `PFRA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  // a pending beat at command accept must be the previous command's last
  `PFRA_ASSERT_IMP(a_accept_after_last, in_valid && in_ready, !out_valid || out_data.last, "new command before last beat")
  // an eviction beat is never the end of a command
  `PFRA_ASSERT_IMP(a_evict_busy, out_valid && out_data.evict, !in_ready && !out_data.last, "eviction beat while idle")

endmodule

FILE: bench/page_frame_run_allocator_tb.sv
// Testbench for page_frame_run_allocator: directed and random command streams checked
// beat by beat against a frame-table predictor kept here.
// Depends on pfra_pkg and the page_frame_run_allocator RTL.
module page_frame_run_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfra_pkg::*;

  localparam int NUM_PAGES = 1024;
  localparam int MAX_RUN   = 32;
  localparam int SINK_HOLD = 600;
  localparam int DRAIN_TAIL = 50;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index = CFG_TOTAL;
  logic [CNT_W-1:0] cfg_data = '0;

  page_frame_run_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // predicted frame table
  frame_t           frame_st [NUM_PAGES];
  logic [5:0]       run_len  [NUM_PAGES];
  int unsigned      in_use;
  logic [CNT_W-1:0] reg_total;
  logic [CNT_W-1:0] reg_reserved;

  out_item_t pending_results[$];
  int        errors = 0;
  bit        src_steady = 1'b0;
  bit        sink_steady = 1'b0;
  int        hold_request = 0;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned managed_frames();
    return (reg_total > NUM_PAGES) ? NUM_PAGES : reg_total;
  endfunction

  function automatic void push_result(status_t st, int unsigned idx, logic ev, logic lst);
    out_item_t r;
    r.status     = st;
    r.page_index = PIDX_W'(idx);
    r.evict      = ev;
    r.used_pages = CNT_W'(in_use);
    r.last       = lst;
    pending_results.push_back(r);
  endfunction

  function automatic int find_first_fit(int unsigned n, int unsigned t, bit allow_user);
    int unsigned run = 0;
    for (int unsigned i = 0; i < t; i++) begin
      if (frame_st[i] == FS_FREE || (allow_user && frame_st[i] == FS_USER)) begin
        run++;
        if (run == n) return int'(i + 1 - n);
      end else begin
        run = 0;
      end
    end
    return -1;
  endfunction

  function automatic void claim_frames(int unsigned n, frame_t kind);
    int unsigned t;
    int          start;
    int unsigned p;
    int unsigned victims[$];
    t = managed_frames();
    start = find_first_fit(n, t, in_use >= t);
    if (start < 0) begin
      push_result(ST_NO_RUN, 0, 1'b0, 1'b1);
      return;
    end
    for (int unsigned j = 0; j < n; j++) begin
      p = start + j;
      if (frame_st[p] == FS_USER) victims.push_back(p);
      else in_use++;
      frame_st[p] = kind;
      run_len[p] = '0;
    end
    run_len[start] = 6'(n);
    foreach (victims[v]) push_result(ST_OK, victims[v], 1'b1, 1'b0);
    push_result(ST_OK, start, 1'b0, 1'b1);
  endfunction

  function automatic void apply_command(in_item_t c);
    int unsigned t;
    int unsigned r;
    int unsigned len;
    int unsigned fi;
    t = managed_frames();
    fi = c.free_index;
    case (c.func)
      FN_INIT: begin
        r = (reg_reserved > t) ? t : reg_reserved;
        for (int unsigned i = 0; i < NUM_PAGES; i++) begin
          frame_st[i] = (i < r) ? FS_FIXED : FS_FREE;
          run_len[i] = '0;
        end
        in_use = r;
        push_result(ST_OK, 0, 1'b0, 1'b1);
      end
      FN_KALLOC: begin
        if (c.run_pages == 0 || c.run_pages > MAX_RUN) push_result(ST_BAD_COUNT, 0, 1'b0, 1'b1);
        else claim_frames(c.run_pages, FS_FIXED);
      end
      FN_UALLOC: claim_frames(1, FS_USER);
      FN_FREE: begin
        if (fi >= t || run_len[fi] == 0) begin
          push_result(ST_NOT_START, fi, 1'b0, 1'b1);
        end else begin
          len = run_len[fi];
          for (int unsigned j = 0; j < len && fi + j < t; j++) begin
            if (frame_st[fi + j] != FS_FREE && in_use > 0) in_use--;
            frame_st[fi + j] = FS_FREE;
            run_len[fi + j] = '0;
          end
          push_result(ST_OK, fi, 1'b0, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [PIDX_W-1:0] pick_run_start();
    int unsigned starts[$];
    for (int unsigned i = 0; i < NUM_PAGES; i++) if (run_len[i] != 0) starts.push_back(i);
    if (starts.size() == 0) return PIDX_W'($urandom_range(0, NUM_PAGES - 1));
    return PIDX_W'(starts[$urandom_range(0, starts.size() - 1)]);
  endfunction

  // caller sits just after a rising edge
  task automatic send_cmd(in_item_t c);
    int unsigned n;
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    apply_command(c);
    n = (src_steady || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(func_t f, int unsigned n, int unsigned idx);
    in_item_t c;
    c.func       = f;
    c.run_pages  = RUNP_W'(n);
    c.free_index = PIDX_W'(idx);
    send_cmd(c);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_config(logic [CNT_W-1:0] total, logic [CNT_W-1:0] reserved);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TOTAL;
    cfg_data  <= total;
    do @(posedge clk); while (!cfg_ready);
    reg_total = total;
    cfg_index <= CFG_RESERVED;
    cfg_data  <= reserved;
    do @(posedge clk); while (!cfg_ready);
    reg_reserved = reserved;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_random_cmd();
    in_item_t    c;
    int unsigned r;
    int unsigned s;
    c.run_pages  = RUNP_W'($urandom_range(0, 63));
    c.free_index = PIDX_W'($urandom_range(0, NUM_PAGES - 1));
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    if (r < 4) begin
      c.func = FN_INIT;
    end else if (r < 44) begin
      c.func = FN_KALLOC;
      if (s >= 5) c.run_pages = RUNP_W'((s < 85) ? $urandom_range(1, 8) : $urandom_range(1, MAX_RUN));
    end else if (r < 72) begin
      c.func = FN_UALLOC;
    end else begin
      c.func = FN_FREE;
      if (s < 85) c.free_index = pick_run_start();
    end
    return c;
  endfunction

  // defaults after reset: total 1024, nothing reserved, table all free
  task automatic test_reset_defaults();
    issue(FN_KALLOC, MAX_RUN, 0);
    issue(FN_UALLOC, 0, 0);
    issue(FN_FREE, 0, 0);
    issue(FN_FREE, 0, MAX_RUN);
    issue(FN_KALLOC, 1, NUM_PAGES - 1);
  endtask

  // bad counts, no run, non-start frees, fill with user pages, then evict
  task automatic test_error_codes();
    set_config(16, 4);
    issue(FN_INIT, 0, 0);
    issue(FN_KALLOC, 0, 0);
    issue(FN_KALLOC, 63, 0);
    issue(FN_KALLOC, MAX_RUN + 1, 0);
    issue(FN_KALLOC, MAX_RUN, 0);
    issue(FN_KALLOC, 12, 0);
    issue(FN_UALLOC, 0, 0);
    issue(FN_FREE, 0, 0);
    issue(FN_FREE, 0, 5);
    issue(FN_FREE, 63, NUM_PAGES - 1);
    issue(FN_FREE, 0, 4);
    repeat (12) issue(FN_UALLOC, 0, 0);
    issue(FN_KALLOC, 5, 0);
    issue(FN_FREE, 0, 4);
    issue(FN_UALLOC, 0, 0);
  endtask

  // runs past a shrunken total, empty table, oversized registers
  task automatic test_limits();
    set_config(16, 0);
    issue(FN_INIT, 0, 0);
    issue(FN_KALLOC, 16, 0);
    set_config(10, 2047);
    issue(FN_FREE, 0, 0);
    issue(FN_FREE, 0, 10);
    issue(FN_INIT, 0, 0);
    issue(FN_UALLOC, 0, 0);
    set_config(0, 0);
    issue(FN_KALLOC, 1, 0);
    issue(FN_UALLOC, 0, 0);
    issue(FN_FREE, 0, 0);
    issue(FN_INIT, 0, 0);
    set_config(2047, 1024);
    issue(FN_INIT, 0, 0);
    issue(FN_UALLOC, 0, 0);
    issue(FN_KALLOC, MAX_RUN, 0);
  endtask

  // receiver holds off while commands keep coming, then the sender drains
  task automatic test_backpressure();
    set_config(64, 0);
    issue(FN_INIT, 0, 0);
    src_steady = 1'b1;
    hold_request = SINK_HOLD;
    for (int i = 0; i < 20; i++) begin
      if (i % 3 == 0) issue(FN_KALLOC, $urandom_range(1, 6), 0);
      else issue(FN_UALLOC, 0, 0);
    end
    wait_drained();
    repeat (8) issue(FN_UALLOC, 0, 0);
    src_steady = 1'b0;
  endtask

  task automatic test_random_mix(logic [CNT_W-1:0] total, logic [CNT_W-1:0] reserved,
                                 int unsigned count);
    set_config(total, reserved);
    issue(FN_INIT, 0, 0);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      send_cmd(make_random_cmd());
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // result sink with random stalls and the long hold-off
  initial begin : sink
    int unsigned wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        wait_left = hold_request;
        hold_request = 0;
      end
      if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else if (!sink_steady && $urandom_range(0, 2) == 0) begin
        wait_left = gap_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("page_index", want.page_index, out_data.page_index);
        check_field("evict", want.evict, out_data.evict);
        check_field("used_pages", want.used_pages, out_data.used_pages);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_PAGES; i++) begin
      frame_st[i] = FS_FREE;
      run_len[i] = '0;
    end
    in_use = 0;
    reg_total = TOTAL_RST;
    reg_reserved = RESERVED_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_error_codes();
    test_limits();
    test_backpressure();
    test_random_mix(64, 8, 110);
    test_random_mix(40, 0, 110);
    test_random_mix(1024, 0, 50);
    test_random_mix(1, 0, 25);
    test_random_mix(1024, 1024, 15);
    test_random_mix(200, 3, 50);
    test_random_mix(0, 5, 20);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result beats never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
